// File: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL files; only the tracker top module includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rstn, ante, cons)

`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// File: hw/rtl/rsync_pkg.sv
`default_nettype none

package rsync_pkg;

    localparam int NUM_REPLICAS = 16;
    localparam int ID_LIMIT     = (NUM_REPLICAS < 16) ? NUM_REPLICAS : 16;
    localparam int IDX_W        = (ID_LIMIT > 1) ? $clog2(ID_LIMIT) : 1;

    localparam int ID_W     = 4;
    localparam int MASK_W   = 16;
    localparam int OFF_W    = 63;
    localparam int TIME_W   = 48;
    localparam int LAG_T_W  = 16;
    localparam int LAG_M_W  = 32;
    localparam int REQ_W    = 2;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam int S_DATA_W = 184;
    localparam int M_DATA_W = 80;

    localparam logic [REQ_W-1:0] REQ_FETCH  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SWEEP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REP_MASK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAG_TIME  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAG_MSGS  = 2'd3;

    typedef struct packed {
        logic [OFF_W-1:0]  offset;
        logic [TIME_W-1:0] fetch_time;
    } entry_t;

endpackage

`default_nettype wire

// File: hw/rtl/rsync_state_mem.sv
`default_nettype none

module rsync_state_mem (
    input  wire logic                      aclk,
    input  wire logic                      wr_en,
    input  wire logic [rsync_pkg::IDX_W-1:0] wr_addr,
    input  wire rsync_pkg::entry_t         wr_data,
    input  wire logic                      rd_en,
    input  wire logic [rsync_pkg::IDX_W-1:0] rd_addr,
    output rsync_pkg::entry_t              rd_data
);
    import rsync_pkg::*;

    entry_t mem_reg [ID_LIMIT];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/replica_sync_tracker_top.sv
`default_nettype none
// Replica sync tracker for one leader partition.
// The input stream carries one word per request: s_tuser holds the request
// kind (fetch, append or sweep) and s_tdata the replica id, fetch offset,
// current time and log end offset. Each word produces exactly one result
// word on the output stream with the in-sync mask, the high watermark and,
// in m_tuser, a flag that is set when the in-sync set changed.
// The user must write registers through the cfg port while the block is
// idle; the block itself does not enforce this. A fetch writes the
// follower's offset and time into an entry memory in the accept cycle; the
// block then reads the sixteen entries one per cycle through a three-stage
// read, check and merge pipeline. One word is processed at a time. The
// finished result sits in an output register; when the receiver stalls it
// is held there, the next word can be accepted, and that word's result
// waits in the merge registers until the output is free. Reset clears the
// fetched flags and the in-sync set and loads the register defaults; the
// entry memory needs no clearing since unfetched entries are never used.

`include "assert_macros.svh"

module replica_sync_tracker_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [rsync_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rsync_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    // replica_id, fetch_offset, now_ms, end_offset, zero fill
    input  wire logic [rsync_pkg::S_DATA_W-1:0]  s_tdata,
    // req_type
    input  wire logic [rsync_pkg::REQ_W-1:0]     s_tuser,
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    // isr_mask, watermark, zero fill
    output      logic [rsync_pkg::M_DATA_W-1:0]  m_tdata,
    // isr_changed
    output      logic                            m_tuser
);
    import rsync_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ID_LIMIT - 1);
    localparam logic [ID_W:0]    ID_LIM_V = (ID_W+1)'(ID_LIMIT);

    logic [ID_W-1:0]    self_id_reg;
    logic [MASK_W-1:0]  replica_mask_reg;
    logic [LAG_T_W-1:0] lag_time_reg;
    logic [LAG_M_W-1:0] lag_msgs_reg;
    logic [MASK_W-1:0]  has_fetched_reg;
    logic [MASK_W-1:0]  current_isr_reg;

    logic [1:0]         state_reg;
    logic [IDX_W-1:0]   cnt_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [OFF_W-1:0]   leo_reg;

    logic               s1_vld_reg;
    logic               s1_last_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic               s2_vld_reg;
    logic               s2_last_reg;
    logic               s2_ok_reg;
    logic [IDX_W-1:0]   s2_idx_reg;
    logic [OFF_W-1:0]   s2_off_reg;

    logic [MASK_W-1:0]  isr_acc_reg;
    logic [OFF_W-1:0]   hwm_acc_reg;

    logic               m_tvalid_reg;
    logic [MASK_W-1:0]  m_isr_reg;
    logic [OFF_W-1:0]   m_hwm_reg;
    logic               m_chg_reg;

    logic [REQ_W-1:0]   in_req;
    logic [ID_W-1:0]    in_rid;
    logic [OFF_W-1:0]   in_foff;
    logic [TIME_W-1:0]  in_now;
    logic [OFF_W-1:0]   in_leo;

    logic               accept;
    logic               mem_we;
    entry_t             mem_wdata;
    logic               rd_en;
    entry_t             rd_data;
    logic               out_load;

    logic [TIME_W-1:0]  dt;
    logic [OFF_W:0]     gap;
    logic               time_ok;
    logic               gap_ok;
    logic [ID_W-1:0]    s1_id;
    logic [ID_W-1:0]    s2_id;
    logic [MASK_W-1:0]  s2_bit;

    assign in_req  = s_tuser;
    assign in_rid  = s_tdata[3:0];
    assign in_foff = s_tdata[66:4];
    assign in_now  = s_tdata[114:67];
    assign in_leo  = s_tdata[177:115];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign mem_we   = accept && (in_req == REQ_FETCH) && ({1'b0, in_rid} < ID_LIM_V);
    assign mem_wdata.offset     = in_foff;
    assign mem_wdata.fetch_time = in_now;
    assign rd_en    = (state_reg == ST_SCAN);
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    rsync_state_mem u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (in_rid[IDX_W-1:0]),
        .wr_data (mem_wdata),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg),
        .rd_data (rd_data)
    );

    assign s1_id   = ID_W'(s1_idx_reg);
    assign s2_id   = ID_W'(s2_idx_reg);
    assign s2_bit  = MASK_W'(1) << s2_id;
    assign dt      = now_reg - rd_data.fetch_time;
    assign gap     = {1'b0, leo_reg} - {1'b0, rd_data.offset};
    assign time_ok = (dt[TIME_W-1:LAG_T_W] == '0) && (dt[LAG_T_W-1:0] <= lag_time_reg);
    assign gap_ok  = !gap[OFF_W] && (gap[OFF_W-1:LAG_M_W] == '0)
                     && (gap[LAG_M_W-1:0] <= lag_msgs_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            self_id_reg      <= '0;
            replica_mask_reg <= '0;
            lag_time_reg     <= LAG_T_W'(1000);
            lag_msgs_reg     <= LAG_M_W'(1000);
            current_isr_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_SELF_ID:  self_id_reg <= cfg_wdata[ID_W-1:0];
                    CFG_REP_MASK: begin
                        replica_mask_reg <= cfg_wdata[MASK_W-1:0];
                        if (current_isr_reg == '0) begin
                            current_isr_reg <= cfg_wdata[MASK_W-1:0];
                        end
                    end
                    CFG_LAG_TIME: lag_time_reg <= cfg_wdata[LAG_T_W-1:0];
                    CFG_LAG_MSGS: lag_msgs_reg <= cfg_wdata[LAG_M_W-1:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                current_isr_reg <= isr_acc_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            has_fetched_reg <= '0;
            s1_vld_reg      <= 1'b0;
            s1_last_reg     <= 1'b0;
            s2_vld_reg      <= 1'b0;
            s2_last_reg     <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            s1_vld_reg  <= rd_en;
            s1_last_reg <= rd_en && (cnt_reg == LAST_IDX);
            s2_vld_reg  <= s1_vld_reg;
            s2_last_reg <= s1_last_reg;
            if (mem_we) begin
                has_fetched_reg[in_rid[IDX_W-1:0]] <= 1'b1;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_SCAN;
                        cnt_reg   <= '0;
                    end
                end
                ST_SCAN: begin
                    if (cnt_reg == LAST_IDX) begin
                        state_reg <= ST_WAIT;
                    end else begin
                        cnt_reg <= cnt_reg + IDX_W'(1);
                    end
                end
                ST_WAIT: begin
                    if (s2_vld_reg && s2_last_reg) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            now_reg     <= in_now;
            leo_reg     <= in_leo;
            isr_acc_reg <= '0;
            hwm_acc_reg <= in_leo;
        end else if (s2_vld_reg) begin
            if (s2_id == self_id_reg) begin
                isr_acc_reg <= isr_acc_reg | s2_bit;
            end else if (s2_ok_reg) begin
                isr_acc_reg <= isr_acc_reg | s2_bit;
                if (s2_off_reg < hwm_acc_reg) begin
                    hwm_acc_reg <= s2_off_reg;
                end
            end
        end
        s1_idx_reg <= cnt_reg;
        s2_idx_reg <= s1_idx_reg;
        s2_off_reg <= rd_data.offset;
        s2_ok_reg  <= replica_mask_reg[s1_id] && has_fetched_reg[s1_id] && time_ok && gap_ok;
        if (out_load) begin
            m_isr_reg <= isr_acc_reg;
            m_hwm_reg <= hwm_acc_reg;
            m_chg_reg <= (isr_acc_reg != current_isr_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_hwm_reg, m_isr_reg};
    assign m_tuser  = m_chg_reg;

    `ASSERT_NEXT(a_one_item, aclk, aresetn, accept, !s_tready)
    `ASSERT_IMPLY(a_load_busy, aclk, aresetn, out_load, s2_vld_reg == 1'b0 && !s_tready)
    `ASSERT_IMPLY(a_hwm_bound, aclk, aresetn, out_load, hwm_acc_reg <= leo_reg)
    `ASSERT_IMPLY(a_leader_in, aclk, aresetn,
                  out_load && ({1'b0, self_id_reg} < ID_LIM_V),
                  isr_acc_reg[self_id_reg])
    `ASSERT_IMPLY(a_scan_busy, aclk, aresetn, s1_vld_reg || s2_vld_reg,
                  state_reg == ST_SCAN || state_reg == ST_WAIT)

endmodule

`default_nettype wire
